// ===== design/dpt_pkg.sv =====
// Package for the dotted path tokenizer: parse modes, result kinds, character codes
// and the state and result structs shared by the step logic and the top level.
// Depends on nothing.
`default_nettype none

package dpt_pkg;

	// Width of the bracketed index that must not overflow.
	localparam int unsigned INDEX_BITS = 32;
	// Accumulate width: room for ten times the index plus one digit.
	localparam int unsigned PROD_BITS = INDEX_BITS + 4;
	localparam int unsigned INDEX_OUT_BITS = 32;

	// Character codes of the path syntax.
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Parser position within the path.
	typedef enum logic [2:0] {
		MODE_START  = 3'd0,
		MODE_KEY    = 3'd1,
		MODE_DOT    = 3'd2,
		MODE_OPEN   = 3'd3,
		MODE_DIGITS = 3'd4,
		MODE_CLOSED = 3'd5
	} mode_t;

	// Kind of each result transfer.
	typedef enum logic [1:0] {
		SEG_NONE  = 2'd0,
		SEG_KEY   = 2'd1,
		SEG_INDEX = 2'd2,
		SEG_END   = 2'd3
	} seg_kind_t;

	typedef struct packed {
		mode_t                   mode;
		logic [INDEX_BITS-1:0]   acc;
		logic                    err;
	} parse_state_t;

	typedef struct packed {
		seg_kind_t                  seg_kind;
		logic [7:0]                 key_char;
		logic                       new_key;
		logic [INDEX_OUT_BITS-1:0]  index_value;
		logic                       syntax_error;
	} seg_result_t;

endpackage

`default_nettype wire

// ===== design/dpt_step.sv =====
// Combinational step of the tokenizer: from the parser state and one path item,
// the next state and the result of that item. Depends on dpt_pkg.
`default_nettype none

module dpt_step (
	input  dpt_pkg::parse_state_t  cur,
	input  logic                   action,
	input  logic [7:0]             ch,
	output dpt_pkg::parse_state_t  nxt,
	output dpt_pkg::seg_result_t   res
);

	logic                              is_digit;
	logic [3:0]                        digit;
	logic [dpt_pkg::INDEX_BITS-1:0]    base;
	logic [dpt_pkg::PROD_BITS-1:0]     base_ext;
	logic [dpt_pkg::PROD_BITS-1:0]     prod;
	logic                              ovf;

	// Digit decode and the times-ten accumulate with its overflow check.
	always_comb begin
		is_digit = (ch >= dpt_pkg::CH_ZERO) && (ch <= dpt_pkg::CH_NINE);
		digit    = 4'(ch - dpt_pkg::CH_ZERO);
		base     = (cur.mode == dpt_pkg::MODE_OPEN) ? '0 : cur.acc;
		base_ext = dpt_pkg::PROD_BITS'(base);
		prod     = (base_ext << 3) + (base_ext << 1) + dpt_pkg::PROD_BITS'(digit);
		ovf      = |prod[dpt_pkg::PROD_BITS-1:dpt_pkg::INDEX_BITS];
	end

	// Mode transitions and the result of this item.
	always_comb begin
		nxt = cur;
		res = '0;
		res.seg_kind = dpt_pkg::SEG_NONE;
		if (action) begin
			// End of path: give the verdict, then return to the reset state.
			res.seg_kind     = dpt_pkg::SEG_END;
			res.syntax_error = cur.err ||
				((cur.mode != dpt_pkg::MODE_KEY) && (cur.mode != dpt_pkg::MODE_CLOSED));
			nxt.mode = dpt_pkg::MODE_START;
			nxt.acc  = '0;
			nxt.err  = 1'b0;
		end else if (!cur.err) begin
			unique case (cur.mode)
				dpt_pkg::MODE_START, dpt_pkg::MODE_DOT: begin
					if (ch == dpt_pkg::CH_DOT ||
					    (ch == dpt_pkg::CH_OPEN && cur.mode == dpt_pkg::MODE_DOT)) begin
						nxt.err = 1'b1;
					end else if (ch == dpt_pkg::CH_OPEN) begin
						nxt.mode = dpt_pkg::MODE_OPEN;
					end else begin
						nxt.mode     = dpt_pkg::MODE_KEY;
						res.seg_kind = dpt_pkg::SEG_KEY;
						res.key_char = ch;
						res.new_key  = 1'b1;
					end
				end
				dpt_pkg::MODE_KEY: begin
					if (ch == dpt_pkg::CH_DOT) begin
						nxt.mode = dpt_pkg::MODE_DOT;
					end else if (ch == dpt_pkg::CH_OPEN) begin
						nxt.mode = dpt_pkg::MODE_OPEN;
					end else begin
						res.seg_kind = dpt_pkg::SEG_KEY;
						res.key_char = ch;
					end
				end
				dpt_pkg::MODE_OPEN, dpt_pkg::MODE_DIGITS: begin
					if (is_digit) begin
						if (ovf) begin
							nxt.err = 1'b1;
						end else begin
							nxt.acc  = prod[dpt_pkg::INDEX_BITS-1:0];
							nxt.mode = dpt_pkg::MODE_DIGITS;
						end
					end else if (ch == dpt_pkg::CH_CLOSE &&
					             cur.mode == dpt_pkg::MODE_DIGITS) begin
						nxt.mode        = dpt_pkg::MODE_CLOSED;
						nxt.acc         = '0;
						res.seg_kind    = dpt_pkg::SEG_INDEX;
						res.index_value = dpt_pkg::INDEX_OUT_BITS'(cur.acc);
					end else begin
						nxt.err = 1'b1;
					end
				end
				dpt_pkg::MODE_CLOSED: begin
					if (ch == dpt_pkg::CH_OPEN) begin
						nxt.mode = dpt_pkg::MODE_OPEN;
					end else if (ch == dpt_pkg::CH_DOT) begin
						nxt.mode = dpt_pkg::MODE_DOT;
					end else begin
						nxt.err = 1'b1;
					end
				end
				default: begin
					nxt.err = 1'b1;
				end
			endcase
			res.syntax_error = nxt.err;
		end else begin
			// Sticky error: path bytes give no segment, only the error flag, until the end of path.
			res.syntax_error = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== design/dotted_path_tokenizer_core.sv =====
// Top level of the dotted path tokenizer: input register, parser state and
// result register around the combinational step. Depends on dpt_pkg and dpt_step.
//
// Channel  | Dir | tvalid/tready      | tdata                               | other
// ---------+-----+--------------------+-------------------------------------+---------------
// s        | in  | s_tvalid/s_tready  | [7:0] ch                            | s_tlast action
// m        | out | m_tvalid/m_tready  | [7:0] key_char [39:8] index_value   | m_tuser [1:0]
//          |     |                    | [40] syntax_error, rest zero        | seg_kind [2] new_key
//
// Every input transfer gives exactly one result transfer, held first in the input
// register and then in the result register. One item is accepted each cycle while
// the output is not stalled: the parser state is updated as the item moves from the
// input register into the result register. A stalled output holds the result register
// and the input register keeps one more item; ready drops only when both are full.
// Reset clears the parser state and both valid flags; no other start-up is needed.
`default_nettype none

module dotted_path_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // action: end of path
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] key_char, [39:8] index_value, [40] syntax_error
	output logic [2:0]  m_tuser    // [1:0] seg_kind, [2] new_key
);

	logic                   valid_s1;
	logic                   action_s1;
	logic [7:0]             ch_s1;
	logic                   out_valid_q;
	dpt_pkg::seg_result_t   out_q;
	dpt_pkg::parse_state_t  state_q;
	dpt_pkg::parse_state_t  state_nxt;
	dpt_pkg::seg_result_t   step_res;
	logic                   advance;

	// The result register can take a new result when empty or being emptied.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tlast;
			ch_s1     <= s_tdata;
		end
	end

	dpt_step u_step (
		.cur    (state_q),
		.action (action_s1),
		.ch     (ch_s1),
		.nxt    (state_nxt),
		.res    (step_res)
	);

	// Parser state and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= dpt_pkg::MODE_START;
			state_q.acc  <= '0;
			state_q.err  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= step_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q.syntax_error, out_q.index_value, out_q.key_char};
	assign m_tuser  = {out_q.new_key, out_q.seg_kind};

	// The end of path returns the parser to its reset state.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && action_s1) |=>
		(state_q.mode == dpt_pkg::MODE_START && !state_q.err && state_q.acc == '0))
		else $error("parser state not cleared after end of path");

	// A syntax error stays until the end of path.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.err && !(valid_s1 && advance && action_s1)) |=> state_q.err)
		else $error("syntax error cleared before end of path");

	// The accumulator holds a value only while digits are being read.
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode != dpt_pkg::MODE_DIGITS) |-> (state_q.acc == '0))
		else $error("index accumulator not zero outside digits");

	// A waiting item in the input register is kept while the output stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(ch_s1) && $stable(action_s1)))
		else $error("input register lost an item during a stall");

endmodule

`default_nettype wire

// ===== dv/dpt_segment_check.sv =====
// Checker for the dotted path tokenizer: watches both stream channels, predicts each
// result from the accepted path bytes and compares it field by field.
// Depends on dpt_pkg for the parse modes, result kinds and character codes.
`default_nettype none

module dpt_segment_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // action: end of path
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // [7:0] key_char, [39:8] index_value, [40] syntax_error
	input  logic [2:0]  m_tuser,   // [1:0] seg_kind, [2] new_key
	output int          fail_count,
	output int          outstanding
);

	import dpt_pkg::*;

	// Largest index that still fits in the configured width.
	localparam logic [63:0] INDEX_MAX = (INDEX_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
		((64'd1 << INDEX_BITS) - 64'd1);

	// Shadow copy of the parser state.
	mode_t       path_mode = MODE_START;
	logic [63:0] index_acc = '0;
	logic        error_flag = 1'b0;

	seg_result_t expected_segments[$];
	int          fails = 0;

	// Advances the shadow parser by one byte or end of path and gives the result.
	function automatic seg_result_t predict_segment(input logic end_of_path, input logic [7:0] c);
		seg_result_t r;
		logic [63:0] digit;
		logic [63:0] base;
		logic [63:0] next_acc;
		r = '0;
		digit = {56'd0, c - CH_ZERO};
		if (end_of_path) begin
			// Only a path ending in a key or a closed index is well formed.
			if (path_mode != MODE_KEY && path_mode != MODE_CLOSED)
				error_flag = 1'b1;
			r.seg_kind = SEG_END;
			r.syntax_error = error_flag;
			path_mode = MODE_START;
			index_acc = '0;
			error_flag = 1'b0;
			return r;
		end
		if (error_flag) begin
			r.syntax_error = 1'b1;
			return r;
		end
		case (path_mode)
			MODE_START, MODE_DOT: begin
				if (c == CH_DOT || (c == CH_OPEN && path_mode == MODE_DOT)) begin
					error_flag = 1'b1;
				end else if (c == CH_OPEN) begin
					path_mode = MODE_OPEN;
				end else begin
					path_mode = MODE_KEY;
					r.seg_kind = SEG_KEY;
					r.key_char = c;
					r.new_key = 1'b1;
				end
			end
			MODE_KEY: begin
				if (c == CH_DOT) begin
					path_mode = MODE_DOT;
				end else if (c == CH_OPEN) begin
					path_mode = MODE_OPEN;
				end else begin
					r.seg_kind = SEG_KEY;
					r.key_char = c;
				end
			end
			MODE_OPEN, MODE_DIGITS: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					base = (path_mode == MODE_OPEN) ? 64'd0 : index_acc;
					next_acc = base * 64'd10 + digit;
					if (next_acc > INDEX_MAX) begin
						error_flag = 1'b1;
					end else begin
						index_acc = next_acc;
						path_mode = MODE_DIGITS;
					end
				end else if (c == CH_CLOSE && path_mode == MODE_DIGITS) begin
					r.seg_kind = SEG_INDEX;
					r.index_value = index_acc[INDEX_OUT_BITS-1:0];
					path_mode = MODE_CLOSED;
					index_acc = '0;
				end else begin
					error_flag = 1'b1;
				end
			end
			MODE_CLOSED: begin
				if (c == CH_OPEN)
					path_mode = MODE_OPEN;
				else if (c == CH_DOT)
					path_mode = MODE_DOT;
				else
					error_flag = 1'b1;
			end
			default: begin
				error_flag = 1'b1;
			end
		endcase
		r.syntax_error = error_flag;
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		fails++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	// Result transfers are checked before the input transfer of the same edge is
	// predicted, as a result can never leave in the cycle its byte arrives.
	always @(posedge clk or negedge arst_n) begin
		seg_result_t want;
		if (!arst_n) begin
			expected_segments.delete();
			path_mode = MODE_START;
			index_acc = '0;
			error_flag = 1'b0;
			fails = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_segments.size() == 0) begin
					fails++;
					$display("%0t: result transfer with nothing expected, actual tuser %0h tdata %0h",
						$time, m_tuser, m_tdata);
				end else begin
					want = expected_segments.pop_front();
					if (m_tuser[1:0] !== want.seg_kind)
						note_mismatch("seg_kind", 64'(want.seg_kind), 64'(m_tuser[1:0]));
					if (m_tuser[2] !== want.new_key)
						note_mismatch("new_key", 64'(want.new_key), 64'(m_tuser[2]));
					if (m_tdata[7:0] !== want.key_char)
						note_mismatch("key_char", 64'(want.key_char), 64'(m_tdata[7:0]));
					if (m_tdata[39:8] !== want.index_value)
						note_mismatch("index_value", 64'(want.index_value), 64'(m_tdata[39:8]));
					if (m_tdata[40] !== want.syntax_error)
						note_mismatch("syntax_error", 64'(want.syntax_error), 64'(m_tdata[40]));
					if (m_tdata[47:41] !== 7'd0)
						note_mismatch("tdata padding", 64'd0, 64'(m_tdata[47:41]));
				end
			end
			// Queue the prediction for each accepted input transfer at the tail.
			if (s_tvalid && s_tready)
				expected_segments.insert(expected_segments.size(),
					predict_segment(s_tlast, s_tdata));
			fail_count <= fails;
			outstanding <= expected_segments.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench top for the dotted path tokenizer: clock, reset, path stimulus with
// random idling on both channels, watchdog and verdict.
// Depends on dpt_pkg, dotted_path_tokenizer_core and dpt_segment_check.
`default_nettype none

module tb;

	import dpt_pkg::*;

	localparam int TOTAL_ITEMS    = 1950;
	localparam int CALM_ITEMS     = 300;
	localparam int HOLD_AT        = 600;
	localparam int DRAIN_AT       = 1200;
	localparam int LONG_HOLD      = 200;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	int          fail_count;
	int          outstanding;

	// Stimulus phase flags shared with the receiver process.
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int bytes_sent = 0;

	always #5 clk = ~clk;

	dotted_path_tokenizer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	dpt_segment_check u_check (.*);

	// Offers one item and waits for its transfer, sometimes idling first.
	task automatic push_char(input logic end_of_path, input logic [7:0] c);
		if (!calm && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= end_of_path;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic end_path();
		push_char(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(1'b0, s[i]);
	endtask

	// A byte biased towards the characters that steer the parser.
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 4))
			0: return CH_DOT;
			1: return CH_OPEN;
			2: return CH_CLOSE;
			3: return CH_ZERO + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Path byte with an occasional corruption.
	task automatic emit(input logic [7:0] c);
		if ($urandom_range(0, 59) == 0)
			c = noise_byte();
		push_char(1'b0, c);
	endtask

	// Bracketed index, with the extremes of the range and overflow favoured.
	task automatic emit_index();
		longint unsigned value;
		string digits;
		case ($urandom_range(0, 7))
			0: value = 0;
			1: value = 64'd4294967295;
			2: value = 64'd4294967296 + 64'($urandom_range(0, 20));
			3: value = 64'($urandom);
			default: value = 64'($urandom_range(0, 999));
		endcase
		digits = $sformatf("%0d", value);
		emit(CH_OPEN);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) emit(CH_ZERO);
		for (int i = 0; i < digits.len(); i++)
			emit(digits[i]);
		// Now and then the bracket is left open.
		if ($urandom_range(0, 15) != 0)
			emit(CH_CLOSE);
	endtask

	// Mostly well-formed paths with random content, the rest noise.
	task automatic random_path();
		int segments;
		int prev_kind;
		logic [7:0] c;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) push_char(1'b0, noise_byte());
		end else begin
			segments = $urandom_range(1, 4);
			prev_kind = 0;
			repeat (segments) begin
				if ($urandom_range(0, 2) == 0) begin
					emit_index();
					prev_kind = 2;
				end else begin
					if (prev_kind != 0)
						emit(CH_DOT);
					repeat ($urandom_range(1, 4)) begin
						c = 8'($urandom_range(0, 255));
						if (c == CH_DOT || c == CH_OPEN)
							c = "k";
						emit(c);
					end
					prev_kind = 1;
				end
			end
			// A stray byte before the end gives trailing dots and glued keys.
			if ($urandom_range(0, 9) == 0)
				push_char(1'b0, noise_byte());
		end
		end_path();
	endtask

	// Receiver: random stalls, ready stretches and one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_tready <= 1'b1;
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 40) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(30, 100)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	initial begin
		int quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("** dotted_path_tokenizer_core: FAILED **");
		$finish;
	end

	// Main stimulus.
	initial begin
		bit hold_done = 1'b0;
		bit drain_done = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed paths: empty path, leading, doubled and trailing dots, dot then
		// bracket, empty, non-digit and unclosed brackets, a key glued after a
		// closing bracket, a closing bracket and extreme bytes inside a key, and a
		// well-formed path with leading zeros.
		end_path();
		push_char(1'b0, CH_DOT);
		end_path();
		push_text("a..q");
		end_path();
		push_text("a.[");
		end_path();
		push_char(1'b0, 8'h00);
		push_char(1'b0, CH_CLOSE);
		push_char(1'b0, CH_DOT);
		end_path();
		push_text("[]");
		end_path();
		push_text("[x");
		end_path();
		push_text("[7");
		end_path();
		push_text("[0]");
		push_char(1'b0, 8'hFF);
		end_path();
		push_text("z[07]");
		end_path();

		// Random paths, with a long receiver hold-off and a full drain on the way.
		while (bytes_sent < TOTAL_ITEMS) begin
			if (!hold_done && bytes_sent >= HOLD_AT) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && bytes_sent >= DRAIN_AT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
				drain_done = 1'b1;
			end
			if (bytes_sent >= TOTAL_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			random_path();
		end

		// Let every result out, then allow for the pipeline to settle.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("** dotted_path_tokenizer_core: PASSED **");
		else
			$display("** dotted_path_tokenizer_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
